/* rtl/u2u_pkg.sv */
// Shared types and constants of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
`default_nettype none
package u2u_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_LONG     = 3'd2,
    ST_BAD_CONT = 3'd3,
    ST_UNTERM   = 3'd4,
    ST_BOUND    = 3'd5
  } status_t;

  // One queue entry: everything the back end needs to emit one or two results.
  typedef struct packed {
    logic [15:0] unit;      // first (or only) code unit
    logic [9:0]  low_bits;  // payload of the low surrogate when pair is set
    logic        pair;      // a low surrogate follows the first unit
    status_t     status;
    logic        done;      // the result ends the string
  } entry_t;

  localparam logic [20:0] MAX_POINT    = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;  // 0xDC00 >> 10
  localparam logic [1:0]  CONT_TAG     = 2'b10;      // top bits of a continuation byte

endpackage
`default_nettype wire

/* rtl/u2u_if.sv */
// Valid/ready channel interfaces for the byte input and the code unit output.
`timescale 1ns / 1ps
`default_nettype none
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [2:0]  status;
  logic        last_of_run;
  logic        string_done;

  modport source (output valid, output code_unit, output status, output last_of_run,
                  output string_done, input ready);
  modport sink   (input valid, input code_unit, input status, input last_of_run,
                  input string_done, output ready);
endinterface
`default_nettype wire

/* rtl/u2u_front.sv */
// Front end: accepts bytes, tracks the decode state and queues result entries.
`timescale 1ns / 1ps
`default_nettype none
module u2u_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [31:0]     bound,
  u2u_in_if.sink               in_ch,
  input  wire logic            q_full,
  output logic                 push,
  output u2u_pkg::entry_t      push_entry
);

  logic [20:0] pp_r, pp_nxt;
  logic [1:0]  due_r, due_nxt;
  logic [31:0] total_r, total_nxt;
  logic        disc_r, disc_nxt;
  logic        acc;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [7:0]        b;
    logic              fin;
    logic [31:0]       count;
    logic [20:0]       cp;
    logic [20:0]       ofs;
    logic              complete;
    logic              err;
    logic              emit;
    logic              clear;
    u2u_pkg::status_t  err_st;

    b         = in_ch.in_byte;
    fin       = in_ch.last_byte;
    count     = (&total_r) ? total_r : total_r + 32'd1;
    cp        = '0;
    ofs       = '0;
    complete  = 1'b0;
    err       = 1'b0;
    emit      = 1'b0;
    clear     = 1'b0;
    err_st    = u2u_pkg::ST_OK;
    pp_nxt    = pp_r;
    due_nxt   = due_r;
    total_nxt = total_r;
    disc_nxt  = disc_r;
    push_entry = '0;

    if (disc_r) begin
      // drop bytes until the end of the string
      clear = fin;
    end else begin
      total_nxt = count;
      if (bound != 32'd0 && count >= bound) begin
        err    = 1'b1;
        err_st = u2u_pkg::ST_BOUND;
      end else if (due_r == 2'd0) begin
        priority if (!b[7]) begin
          cp       = {13'd0, b};
          complete = 1'b1;
        end else if (!b[6]) begin
          err    = 1'b1;
          err_st = u2u_pkg::ST_BAD_LEAD;
        end else if (!b[5]) begin
          pp_nxt  = {16'd0, b[4:0]};
          due_nxt = 2'd1;
        end else if (!b[4]) begin
          pp_nxt  = {17'd0, b[3:0]};
          due_nxt = 2'd2;
        end else if (!b[3]) begin
          pp_nxt  = {18'd0, b[2:0]};
          due_nxt = 2'd3;
        end else begin
          err    = 1'b1;
          err_st = u2u_pkg::ST_LONG;
        end
      end else if (b[7:6] != u2u_pkg::CONT_TAG) begin
        err    = 1'b1;
        err_st = u2u_pkg::ST_BAD_CONT;
      end else begin
        cp       = {pp_r[14:0], b[5:0]};
        pp_nxt   = cp;
        due_nxt  = due_r - 2'd1;
        complete = (due_r == 2'd1);
      end

      if (!err) begin
        if (!complete) begin
          if (fin) begin
            err    = 1'b1;
            err_st = u2u_pkg::ST_UNTERM;
          end
        end else begin
          pp_nxt = '0;
          ofs    = cp - u2u_pkg::SUPP_BASE;
          if (cp > u2u_pkg::MAX_POINT) begin
            err    = 1'b1;
            err_st = u2u_pkg::ST_LONG;
          end else if (fin) begin
            if (cp != 21'd0) begin
              err    = 1'b1;
              err_st = u2u_pkg::ST_UNTERM;
            end else begin
              // terminator
              emit            = 1'b1;
              clear           = 1'b1;
              push_entry.done = 1'b1;
            end
          end else if (cp[20:16] == 5'd0) begin
            emit            = 1'b1;
            push_entry.unit = cp[15:0];
          end else begin
            emit                = 1'b1;
            push_entry.unit     = {u2u_pkg::HI_SURR_TAG, ofs[19:10]};
            push_entry.low_bits = ofs[9:0];
            push_entry.pair     = 1'b1;
          end
        end
      end

      if (err) begin
        pp_nxt            = '0;
        due_nxt           = '0;
        disc_nxt          = 1'b1;
        clear             = fin;
        push_entry        = '0;
        push_entry.status = err_st;
        push_entry.done   = 1'b1;
      end
    end

    if (clear) begin
      pp_nxt    = '0;
      due_nxt   = '0;
      total_nxt = '0;
      disc_nxt  = 1'b0;
    end

    push = acc && (err || emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r    <= '0;
      due_r   <= '0;
      total_r <= '0;
      disc_r  <= 1'b0;
    end else if (acc) begin
      pp_r    <= pp_nxt;
      due_r   <= due_nxt;
      total_r <= total_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/u2u_fifo.sv */
// Small register queue of result entries between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module u2u_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire u2u_pkg::entry_t push_entry,
  input  wire logic            pop,
  output u2u_pkg::entry_t      head,
  output logic                 full,
  output logic                 empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  u2u_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign head  = mem_r[rd_ptr_r];
  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      // wrap at the last slot so any depth works
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/u2u_back.sv */
// Back end: pops queue entries and drives one result per cycle while the receiver is ready, splitting pairs.
`timescale 1ns / 1ps
`default_nettype none
module u2u_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire u2u_pkg::entry_t head,
  input  wire logic            q_empty,
  output logic                 pop,
  u2u_out_if.source            out_ch
);

  logic        vld_r, vld_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        last_r, last_nxt;
  logic        done_r, done_nxt;
  logic        pend_r, pend_nxt;
  logic [9:0]  low_r, low_nxt;
  logic        load;

  assign load = !vld_r || out_ch.ready;
  assign pop  = load && !pend_r && !q_empty;

  always_comb begin
    vld_nxt  = vld_r;
    unit_nxt = unit_r;
    st_nxt   = st_r;
    last_nxt = last_r;
    done_nxt = done_r;
    pend_nxt = pend_r;
    low_nxt  = low_r;
    if (load) begin
      priority if (pend_r) begin
        // second half of a surrogate pair
        vld_nxt  = 1'b1;
        unit_nxt = {u2u_pkg::LO_SURR_TAG, low_r};
        st_nxt   = u2u_pkg::ST_OK;
        last_nxt = 1'b1;
        done_nxt = 1'b0;
        pend_nxt = 1'b0;
      end else if (!q_empty) begin
        vld_nxt  = 1'b1;
        unit_nxt = head.unit;
        st_nxt   = head.status;
        last_nxt = !head.pair;
        done_nxt = head.done;
        pend_nxt = head.pair;
        low_nxt  = head.low_bits;
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
    low_r  <= low_nxt;
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.code_unit   = unit_r;
  assign out_ch.status      = st_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.string_done = done_r;

endmodule
`default_nettype wire

/* rtl/utf8_to_utf16_decoder_unit.sv */
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//   channel   direction  handshake            payload
//   in_ch     in         valid / ready        in_byte[7:0], last_byte
//   out_ch    out        valid / ready        code_unit[15:0], status[2:0],
//                                             last_of_run, string_done
//   cfg       in         cfg_we (no wait)     cfg_wdata[31:0] -> string bound
//
// One byte is accepted per cycle whenever the entry queue between front and
// back end has room; one result leaves per cycle while out_ch.ready is high,
// so a surrogate pair holds the output register for both units. A result is
// queued, then registered. Reset (rst_n low, synchronous) clears the decode
// state, the queue and the output register; the bound register resets to zero.
// Output stalls fill the queue and then drop in_ch.ready; bytes that give no
// result still need a free queue slot to be taken.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_utf16_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  u2u_in_if.sink           in_ch,
  u2u_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  // string bound: zero disables the check
  logic [31:0] bound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= '0;
    end else if (cfg_we) begin
      bound_r <= cfg_wdata;
    end
  end

  // front end -> queue
  logic            push;
  u2u_pkg::entry_t push_entry;
  logic            q_full;

  // queue -> back end
  u2u_pkg::entry_t head;
  logic            q_empty;
  logic            pop;

  // Decode each byte and queue the entry it produces, if any.
  u2u_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .bound      (bound_r),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple input acceptance from output stalls.
  u2u_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Drive results, splitting surrogate pairs into two items.
  u2u_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // Never write into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("entry pushed into a full queue");

  // Never pop an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_empty)
    else $error("entry popped from an empty queue");

  // A high surrogate is followed at once by its low surrogate.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=>
      (out_ch.valid && out_ch.last_of_run &&
       out_ch.code_unit[15:10] == u2u_pkg::LO_SURR_TAG))
    else $error("high surrogate not followed by low surrogate");

  // Error results carry a zero unit and end the string.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != u2u_pkg::ST_OK) |->
      (out_ch.string_done && out_ch.last_of_run && out_ch.code_unit == 16'd0))
    else $error("malformed error result");

  // Output is empty right after reset.
  assert property (@(posedge clk) $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

/* dv/utf8_to_utf16_decoder_unit_test.sv */
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
`timescale 1ns / 1ps
module utf8_to_utf16_decoder_unit_test;

  localparam int          STALL_LIMIT   = 2000;  // quiet cycles before the watchdog fires
  localparam int          HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int          SETTLE_CYCLES = 16;    // queue depth plus output register, with margin
  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;

  // One expected code unit, as the output channel carries it.
  typedef struct packed {
    logic [15:0]      unit;
    u2u_pkg::status_t status;
    logic             last_of_run;
    logic             string_done;
  } utf16_result_t;

  // Scoreboard: decodes every accepted byte on its own copy of the decoder
  // state and holds the code units the block still owes.
  class utf16_ledger;
    logic [31:0]   bound;
    logic [20:0]   partial;
    logic [1:0]    due;
    logic [31:0]   taken;
    bit            discarding;
    utf16_result_t due_units[$];
    int unsigned   mismatches;

    function new();
      bound = '0;
      mismatches = 0;
      restart_string();
    endfunction

    function void set_bound(input logic [31:0] value);
      bound = value;
    endfunction

    function void restart_string();
      partial = '0;
      due = '0;
      taken = '0;
      discarding = 0;
    endfunction

    function void emit(input logic [15:0] unit, input u2u_pkg::status_t st,
                       input logic run_end, input logic str_end);
      utf16_result_t r;
      r.unit = unit;
      r.status = st;
      r.last_of_run = run_end;
      r.string_done = str_end;
      due_units.push_back(r);
    endfunction

    // Report one error; drop the rest of the string unless this byte ends it.
    function void reject(input u2u_pkg::status_t st, input logic fin);
      emit(16'h0000, st, 1'b1, 1'b1);
      if (fin) begin
        restart_string();
      end else begin
        partial = '0;
        due = '0;
        discarding = 1;
      end
    endfunction

    function void decode_byte(input logic [7:0] b, input logic fin);
      logic [20:0] point;
      bit          whole;
      whole = 0;
      if (discarding) begin
        if (fin) restart_string();
        return;
      end
      if (taken != 32'hFFFF_FFFF) taken++;
      if (bound != 0 && taken >= bound) begin
        reject(u2u_pkg::ST_BOUND, fin);
        return;
      end
      if (due == 0) begin
        if (b < 8'h80) begin
          partial = {13'd0, b};
          whole = 1;
        end else if (b < 8'hC0) begin
          reject(u2u_pkg::ST_BAD_LEAD, fin);
          return;
        end else if (b < 8'hE0) begin
          partial = {16'd0, b[4:0]};
          due = 2'd1;
        end else if (b < 8'hF0) begin
          partial = {17'd0, b[3:0]};
          due = 2'd2;
        end else if (b < 8'hF8) begin
          partial = {18'd0, b[2:0]};
          due = 2'd3;
        end else begin
          reject(u2u_pkg::ST_LONG, fin);
          return;
        end
      end else begin
        if (b[7:6] != u2u_pkg::CONT_TAG) begin
          reject(u2u_pkg::ST_BAD_CONT, fin);
          return;
        end
        partial = {partial[14:0], b[5:0]};
        due--;
        whole = (due == 0);
      end
      if (!whole) begin
        if (fin) reject(u2u_pkg::ST_UNTERM, fin);
        return;
      end
      point = partial;
      partial = '0;
      if (point > u2u_pkg::MAX_POINT) begin
        reject(u2u_pkg::ST_LONG, fin);
        return;
      end
      if (fin) begin
        if (point != 0) begin
          reject(u2u_pkg::ST_UNTERM, fin);
        end else begin
          emit(16'h0000, u2u_pkg::ST_OK, 1'b1, 1'b1);
          restart_string();
        end
        return;
      end
      if (point < u2u_pkg::SUPP_BASE) begin
        emit(point[15:0], u2u_pkg::ST_OK, 1'b1, 1'b0);
      end else begin
        point = point - u2u_pkg::SUPP_BASE;
        emit(HI_SURR_BASE + {6'd0, point[19:10]}, u2u_pkg::ST_OK, 1'b0, 1'b0);
        emit(LO_SURR_BASE + {6'd0, point[9:0]}, u2u_pkg::ST_OK, 1'b1, 1'b0);
      end
    endfunction

    function void check_unit(input logic [15:0] unit, input logic [2:0] st,
                             input logic run_end, input logic str_end);
      utf16_result_t exp_r;
      if (due_units.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got unit=%h status=%0d last=%b done=%b",
                 $realtime, unit, st, run_end, str_end);
        return;
      end
      exp_r = due_units.pop_front();
      if (exp_r.unit !== unit || exp_r.status !== st ||
          exp_r.last_of_run !== run_end || exp_r.string_done !== str_end) begin
        mismatches++;
        $display("%0t: result mismatch: expected unit=%h status=%0d last=%b done=%b, %s",
                 $realtime, exp_r.unit, exp_r.status, exp_r.last_of_run,
                 exp_r.string_done,
                 $sformatf("got unit=%h status=%0d last=%b done=%b",
                           unit, st, run_end, str_end));
      end
    endfunction

    function int unsigned outstanding();
      return due_units.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  u2u_in_if  in_ch ();
  u2u_out_if out_ch ();

  utf16_ledger ledger = new();

  bit          hold_request = 0;  // main flow asks the receiver for a long hold-off
  int unsigned items_sent   = 0;
  int          burst_left   = 0;
  logic [7:0]  string_bytes[$];

  // Opening directed strings, each entry is {final mark, byte}:
  //   two-, three- and four-byte characters (the last one the top code point,
  //   giving a surrogate pair), an interior zero and a proper terminator;
  //   a stray continuation as lead with the rest dropped up to the mark;
  //   an 0xFF lead on the marked byte; a value above the Unicode range;
  //   a bad continuation with the terminator dropped; a missing terminator;
  //   a sequence cut short by the mark.
  logic [8:0] opening_seq[$] = '{
    9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h000, 9'h100,
    9'h080, 9'h141,
    9'h1FF,
    9'h0F4, 9'h090, 9'h080, 9'h180,
    9'h0E2, 9'h041, 9'h100,
    9'h141,
    9'h1C3
  };

  utf8_to_utf16_decoder_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both channels at the edge; every input changes only by NBA, so the
  // values seen here are the ones the block saw.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      ledger.decode_byte(in_ch.in_byte, in_ch.last_byte);
    if (rst_n && out_ch.valid && out_ch.ready)
      ledger.check_unit(out_ch.code_unit, out_ch.status, out_ch.last_of_run,
                        out_ch.string_done);
  end

  // End the run once nothing has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog: no handshake for %0d cycles, %0d results still due",
             $realtime, STALL_LIMIT, ledger.outstanding());
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: switch among stall patterns, each kept for a random span; on request,
  // hold ready low for a long stretch so the queue fills and input stalls.
  initial begin : receiver
    int mode;
    int span;
    int k;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (k = 0; k < span && !hold_request; k++) begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ((k % 4) != 3);
          default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one byte and hold it until taken. Between bursts, drop valid for a
  // random gap; a zero gap keeps valid high across bursts.
  task automatic offer_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every owed unit has arrived, then give the
  // block time to settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the bound; call only while the block is idle.
  task automatic write_bound(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_bound(value);
  endtask

  function automatic logic [7:0] cont_byte();
    return {u2u_pkg::CONT_TAG, 6'($urandom_range(0, 63))};
  endfunction

  // Build one string: mostly well-formed characters with random payloads
  // and a terminator, now and then corrupted, cut short or pure noise.
  task automatic compose_string();
    int          n_chars;
    int          cut;
    logic [20:0] point;
    string_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 8)) string_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_chars = $urandom_range(0, 6);
    repeat (n_chars) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: string_bytes.push_back(8'($urandom_range(1, 127)));
        6, 7, 8: begin
          string_bytes.push_back({3'b110, 5'($urandom_range(0, 31))});
          string_bytes.push_back(cont_byte());
        end
        9, 10, 11: begin
          string_bytes.push_back({4'b1110, 4'($urandom_range(0, 15))});
          repeat (2) string_bytes.push_back(cont_byte());
        end
        12, 13, 14, 15, 16: begin
          // in-range supplementary character, surrogate pair on the output
          point = 21'($urandom_range(32'h10000, 32'h10FFFF));
          string_bytes.push_back({5'b11110, point[20:18]});
          string_bytes.push_back({u2u_pkg::CONT_TAG, point[17:12]});
          string_bytes.push_back({u2u_pkg::CONT_TAG, point[11:6]});
          string_bytes.push_back({u2u_pkg::CONT_TAG, point[5:0]});
        end
        17, 18: begin
          // any four-byte form, often beyond the Unicode range
          string_bytes.push_back({5'b11110, 3'($urandom_range(0, 7))});
          repeat (3) string_bytes.push_back(cont_byte());
        end
        default: string_bytes.push_back(8'h00);  // interior zero
      endcase
    end
    string_bytes.push_back(8'h00);
    case ($urandom_range(0, 19))
      0, 1: string_bytes[$urandom_range(0, string_bytes.size() - 1)] =
              8'($urandom_range(0, 255));
      2: if (string_bytes.size() > 1) void'(string_bytes.pop_back());
      3: begin
        if (string_bytes.size() > 1) begin
          cut = $urandom_range(1, string_bytes.size() - 1);
          while (string_bytes.size() > cut) void'(string_bytes.pop_back());
        end
      end
      default: ;
    endcase
  endtask

  task automatic run_strings(input int unsigned quota);
    int unsigned stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      compose_string();
      foreach (string_bytes[i])
        offer_byte(string_bytes[i], i == string_bytes.size() - 1);
    end
  endtask

  initial begin : main_flow
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings with the reset bound (unbounded).
    foreach (opening_seq[i]) offer_byte(opening_seq[i][7:0], opening_seq[i][8]);
    wait_drained();

    // Bound hit on the second byte; the terminator is then dropped.
    write_bound(32'd2);
    offer_byte(8'h41, 1'b0);
    offer_byte(8'h41, 1'b0);
    offer_byte(8'h00, 1'b1);
    wait_drained();

    // Unbounded: fill the block under a long receiver hold-off, then pause
    // the sender until every owed unit is out.
    write_bound(32'd0);
    run_strings(200);
    hold_request = 1;
    run_strings(150);
    wait_drained();
    run_strings(150);
    wait_drained();

    // Bound within typical string lengths.
    write_bound(32'($urandom_range(6, 16)));
    run_strings(400);
    wait_drained();

    // Smallest nonzero bound: every string fails on its first byte.
    write_bound(32'd1);
    run_strings(60);
    wait_drained();

    // Largest bound: never reached.
    write_bound(32'hFFFF_FFFF);
    run_strings(400);
    wait_drained();

    // Very tight bound: mostly bound errors mid-character.
    write_bound(32'($urandom_range(2, 5)));
    run_strings(200);
    wait_drained();

    write_bound(32'd0);
    run_strings(300);
    wait_drained();

    if (ledger.mismatches == 0 && ledger.outstanding() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
